FILE: rtl/luhn_card_number_classifier_assert.svh
// Assertion macros used by the checker file of the card number classifier.
// No dependencies; each macro expects clk and rst_n in scope.
`ifndef LUHN_CARD_NUMBER_CLASSIFIER_ASSERT_SVH
`define LUHN_CARD_NUMBER_CLASSIFIER_ASSERT_SVH

// same-cycle implication
`define LUHN_AST_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("luhn classifier check failed");

// next-cycle implication
`define LUHN_AST_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("luhn classifier check failed");

`endif

FILE: rtl/luhn_pkg.sv
// Types, constants and codes for the Luhn card number classifier.
// No dependencies; used by every module of the block.
package luhn_pkg;

    localparam int NUMBER_BITS_DEF = 63;
    localparam int CARD_W          = 63;
    localparam int IN_TDATA_W      = 64;
    localparam int OUT_TDATA_W     = 16;

    localparam int BCD_DIGITS  = 20;
    localparam int DIGIT_W     = 4;
    localparam int STEP_W      = $clog2(BCD_DIGITS);
    localparam int COUNT_W     = 5;
    localparam int SUM_W       = 8;
    localparam int BRAND_W     = 2;

    localparam logic [COUNT_W-1:0] AMEX_DIGITS   = 5'd15;
    localparam logic [COUNT_W-1:0] MC_DIGITS     = 5'd16;
    localparam logic [COUNT_W-1:0] VISA_DIGITS_S = 5'd13;
    localparam logic [COUNT_W-1:0] VISA_DIGITS_L = 5'd16;

    localparam logic [DIGIT_W-1:0] AMEX_LEAD   = 4'd3;
    localparam logic [DIGIT_W-1:0] AMEX_NEXT_A = 4'd4;
    localparam logic [DIGIT_W-1:0] AMEX_NEXT_B = 4'd7;
    localparam logic [DIGIT_W-1:0] MC_LEAD     = 4'd5;
    localparam logic [DIGIT_W-1:0] MC_NEXT_LO  = 4'd1;
    localparam logic [DIGIT_W-1:0] MC_NEXT_HI  = 4'd5;
    localparam logic [DIGIT_W-1:0] VISA_LEAD   = 4'd4;

    typedef enum logic [BRAND_W-1:0] {
        BRAND_INVALID    = 2'd0,
        BRAND_AMEX       = 2'd1,
        BRAND_MASTERCARD = 2'd2,
        BRAND_VISA       = 2'd3
    } brand_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_WALK,
        ST_DONE
    } luhn_state_t;

    typedef logic [BCD_DIGITS-1:0][DIGIT_W-1:0] bcd_digits_t;

    typedef struct packed {
        logic load;
        logic rotate;
    } bcd_ctrl_t;

    typedef struct packed {
        logic busy;
    } bcd_stat_t;

endpackage

FILE: rtl/luhn_bcd.sv
// Bit-serial binary to BCD converter (shift-and-add-3), one input bit per cycle,
// with a digit rotate used by the Luhn walk. Depends on luhn_pkg.
module luhn_bcd #(
    parameter int NUMBER_BITS = luhn_pkg::NUMBER_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  luhn_pkg::bcd_ctrl_t   ctrl,
    input  logic [NUMBER_BITS-1:0] number,
    output luhn_pkg::bcd_stat_t   stat,
    output luhn_pkg::bcd_digits_t digits
);
    import luhn_pkg::*;

    localparam int CNT_W = $clog2(NUMBER_BITS + 1);

    logic [NUMBER_BITS-1:0] shift_reg, shift_next;
    bcd_digits_t            bcd_reg, bcd_next, bcd_adj;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   busy_reg, busy_next;

    always_comb
    begin
        for (int i = 0; i < BCD_DIGITS; i++)
        begin
            bcd_adj[i] = (bcd_reg[i] >= 4'd5) ? bcd_reg[i] + 4'd3 : bcd_reg[i];
        end
    end

    always_comb
    begin
        shift_next = shift_reg;
        bcd_next   = bcd_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        if (ctrl.load)
        begin
            shift_next = number;
            bcd_next   = '0;
            cnt_next   = CNT_W'(NUMBER_BITS);
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            // shift the next msb into the adjusted digit chain
            bcd_next[0] = {bcd_adj[0][DIGIT_W-2:0], shift_reg[NUMBER_BITS-1]};
            for (int i = 1; i < BCD_DIGITS; i++)
            begin
                bcd_next[i] = {bcd_adj[i][DIGIT_W-2:0], bcd_adj[i-1][DIGIT_W-1]};
            end
            shift_next = {shift_reg[NUMBER_BITS-2:0], 1'b0};
            cnt_next   = cnt_reg - CNT_W'(1);
            busy_next  = (cnt_reg != CNT_W'(1));
        end
        else if (ctrl.rotate)
        begin
            bcd_next = {bcd_reg[0], bcd_reg[BCD_DIGITS-1:1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        bcd_reg   <= bcd_next;
    end

    assign stat.busy = busy_reg;
    assign digits    = bcd_reg;

endmodule

FILE: rtl/luhn_card_number_classifier.sv
// Top level of the Luhn card number classifier: sequencer, digit walk, brand decode.
// Depends on luhn_pkg and luhn_bcd.
//
//  channel  dir  tdata fields (low bit up)                        side
//  s_axis   in   card_number[62:0], pad[63]                       tvalid/tready
//  m_axis   out  brand[1:0] luhn_ok[2] luhn_sum[10:3] count[15:11] tvalid/tready
//
// An item goes from accept through the BCD converter, which takes one input bit per cycle,
// and then through the 20-digit walk, which takes one digit per cycle.
// s_axis_tready is high only while the sequencer is idle; a result waits in the
// output register and the next item is taken while it waits.
// Reset clears the sequencer and output valid; no clearing pass is needed.
module luhn_card_number_classifier #(
    parameter int NUMBER_BITS = luhn_pkg::NUMBER_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [luhn_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // card_number[62:0], zero[63]
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [luhn_pkg::OUT_TDATA_W-1:0] m_axis_tdata   // brand, luhn_ok, luhn_sum, digit_count
);
    import luhn_pkg::*;

    localparam int IN_W = (NUMBER_BITS < CARD_W) ? NUMBER_BITS : CARD_W;

    luhn_state_t           state_reg, state_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic [DIGIT_W-1:0]    mod_reg, mod_next;
    logic [COUNT_W-1:0]    count_reg, count_next;
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_TDATA_W-1:0] out_data_reg, out_data_next;

    bcd_ctrl_t             bcd_ctrl;
    bcd_stat_t             bcd_stat;
    bcd_digits_t           digits;
    logic [NUMBER_BITS-1:0] number;

    logic                  accept;
    logic                  load_out;
    logic [DIGIT_W-1:0]    d;
    logic [DIGIT_W:0]      dbl;
    logic [DIGIT_W-1:0]    term;
    logic [DIGIT_W:0]      mod_sum;
    logic                  ok;
    brand_t                brand;

    assign number = NUMBER_BITS'(s_axis_tdata[IN_W-1:0]);

    luhn_bcd #(
        .NUMBER_BITS (NUMBER_BITS)
    ) u_bcd (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (bcd_ctrl),
        .number (number),
        .stat   (bcd_stat),
        .digits (digits)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Luhn term of the digit now at the bottom of the rotating BCD word
    always_comb
    begin
        d    = digits[0];
        dbl  = {d, 1'b0};
        if (step_reg[0])
        begin
            term = (dbl >= 5'd10) ? DIGIT_W'(dbl - 5'd9) : DIGIT_W'(dbl);
        end
        else
        begin
            term = d;
        end
        mod_sum = {1'b0, mod_reg} + {1'b0, term};
    end

    // brand decode on the restored digits after the walk
    always_comb
    begin
        ok    = (mod_reg == '0);
        brand = BRAND_INVALID;
        if (ok)
        begin
            if (count_reg == AMEX_DIGITS && digits[14] == AMEX_LEAD
                && (digits[13] == AMEX_NEXT_A || digits[13] == AMEX_NEXT_B))
            begin
                brand = BRAND_AMEX;
            end
            else if (count_reg == MC_DIGITS && digits[15] == MC_LEAD
                && digits[14] >= MC_NEXT_LO && digits[14] <= MC_NEXT_HI)
            begin
                brand = BRAND_MASTERCARD;
            end
            else if ((count_reg == VISA_DIGITS_S && digits[12] == VISA_LEAD)
                || (count_reg == VISA_DIGITS_L && digits[15] == VISA_LEAD))
            begin
                brand = BRAND_VISA;
            end
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        step_next       = step_reg;
        sum_next        = sum_reg;
        mod_next        = mod_reg;
        count_next      = count_reg;
        bcd_ctrl.load   = 1'b0;
        bcd_ctrl.rotate = 1'b0;
        load_out        = 1'b0;
        out_data_next   = out_data_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    bcd_ctrl.load = 1'b1;
                    step_next     = '0;
                    sum_next      = '0;
                    mod_next      = '0;
                    count_next    = COUNT_W'(1);
                    state_next    = ST_CONV;
                end
            end
            ST_CONV:
            begin
                if (!bcd_stat.busy)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                bcd_ctrl.rotate = 1'b1;
                sum_next = sum_reg + SUM_W'(term);
                mod_next = (mod_sum >= 5'd10) ? DIGIT_W'(mod_sum - 5'd10) : DIGIT_W'(mod_sum);
                if (d != '0)
                begin
                    count_next = COUNT_W'(step_reg) + COUNT_W'(1);
                end
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(BCD_DIGITS - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || m_axis_tready)
                begin
                    load_out      = 1'b1;
                    out_data_next = {count_reg, sum_reg, ok, brand};
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg      <= sum_next;
        mod_reg      <= mod_next;
        count_reg    <= count_next;
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

FILE: rtl/luhn_checker.sv
// Port-level checks for the Luhn card number classifier, bound to the top level.
// Depends on luhn_pkg and luhn_card_number_classifier_assert.svh.
`include "luhn_card_number_classifier_assert.svh"

module luhn_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [luhn_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import luhn_pkg::*;

    `LUHN_AST_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    `LUHN_AST_NXT(a_busy_after_take, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `LUHN_AST_IMP(a_count_range, m_axis_tvalid, m_axis_tdata[15:11] != 5'd0 && m_axis_tdata[15:11] <= 5'd20)
    `LUHN_AST_IMP(a_brand_needs_ok, m_axis_tvalid && m_axis_tdata[1:0] != BRAND_INVALID, m_axis_tdata[2])

endmodule

bind luhn_card_number_classifier luhn_checker u_luhn_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
